// ===== sv/bvdd_pkg.sv =====
// Package for the banded vertical delta decoder: sizing defaults, register
// map codes and pixel format codes. No dependencies.
package bvdd_pkg;

   localparam int DEF_MAX_LINE_PIXELS = 4096;
   localparam int MAX_BYTES_PER_PIXEL = 4;
   localparam int MAX_BAND_ROWS       = 4096;

   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int LINE_PIX_W  = 13;
   localparam int BPP_W       = 3;
   localparam int BAND_W      = 13;
   localparam int ROW_W       = 12;
   localparam int POS_W       = 12;

   // floor(x/3) = (x * DIV3_MULT) >> DIV3_SHIFT for x < 2**17
   localparam logic [31:0] DIV3_MULT  = 32'd43691;
   localparam int          DIV3_SHIFT = 17;

   localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

   typedef enum logic [1:0] {
      REG_LINE_PIXELS   = 2'd0,
      REG_BYTES_PER_PIX = 2'd1,
      REG_ROWS_PER_BAND = 2'd2,
      REG_UNUSED        = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      FMT_ALPHA = 3'd1,
      FMT_PAIR  = 3'd2,
      FMT_RGB   = 3'd3,
      FMT_RGBA  = 3'd4
   } pixel_format_type;

endpackage

// ===== sv/banded_vertical_delta_decoder_unit.sv =====
// Banded vertical delta decoder: line store, counters, reconstruction and
// pixel assembly in one two-stage pipeline. Depends on bvdd_pkg.
//
// Channel  Ports                        Payload
// req      req_tvalid/tready/tdata/tuser tdata: data_byte; tuser: image_start
// rsp      rsp_tvalid/tready/tdata       tdata: red, green, blue, alpha, column, row
// csr      csr_psel/penable/pwrite/...   line_pixels, bytes_per_pixel, rows_per_band
//
// One request per cycle while rsp is not stalled; a pixel goes from stage 1 to the
// output register and rsp once its last byte is taken; the pair format emits none.
// The line store read is registered on accept and the store is written as the item
// leaves stage 1, with a bypass for back-to-back hits on the same byte. Synchronous
// reset clears counters and valid flags; the line store holds no reset value. A
// stalled rsp stops req once stage 1 holds a pixel that cannot move on.
module banded_vertical_delta_decoder_unit
   import bvdd_pkg::*;
#(
   parameter int MAX_LINE_PIXELS = DEF_MAX_LINE_PIXELS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tuser,   // [0] image_start
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] pixel_red, [15:8] pixel_green, [23:16] pixel_blue,
   // [31:24] pixel_alpha, [43:32] pixel_column, [55:44] pixel_row
   output logic [55:0]           rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int STORE_DEPTH = MAX_LINE_PIXELS * MAX_BYTES_PER_PIXEL;
   localparam int COL_W       = $clog2(STORE_DEPTH);
   localparam int LEN_W       = $clog2(STORE_DEPTH + 1);
   localparam int WIDE_W      = (LEN_W > LINE_PIX_W) ? LEN_W : LINE_PIX_W;

   // configuration
   logic [LINE_PIX_W-1:0] line_pixels_ff;
   logic [BPP_W-1:0]      bytes_per_pixel_ff;
   logic [BAND_W-1:0]     rows_per_band_ff;
   logic                  csr_write;
   reg_index_type         csr_index;

   // stage 0 counters
   logic [COL_W-1:0] byte_column_ff, byte_column_in;
   logic [ROW_W-1:0] band_row_ff, band_row_in;
   logic [ROW_W-1:0] image_row_ff, image_row_in;
   logic [1:0]       channel_ff, channel_in;

   logic             req_accept;
   logic [COL_W-1:0] col0;
   logic [ROW_W-1:0] band0;
   logic [ROW_W-1:0] row0;
   logic [1:0]       ch0;
   logic [BPP_W-1:0] bpp_eff;
   logic [WIDE_W-1:0] pix_eff;
   logic [WIDE_W-1:0] line_len;
   logic [BAND_W-1:0] band_eff;
   logic             complete0;
   logic             end_line0;
   logic [POS_W-1:0] pcol0;
   logic [31:0]      div3_prod;

   // stage 1
   logic             s1_valid_ff;
   logic [7:0]       s1_data_ff;
   logic [COL_W-1:0] s1_addr_ff;
   logic             s1_diff_ff;
   logic [1:0]       s1_ch_ff;
   logic             s1_complete_ff;
   logic             s1_emit_ff;
   logic [BPP_W-1:0] s1_bpp_ff;
   logic [POS_W-1:0] s1_pcol_ff;
   logic [ROW_W-1:0] s1_prow_ff;
   logic [7:0]       rd_data_ff;
   logic             fwd_sel_ff;
   logic [7:0]       fwd_data_ff;
   logic [7:0]       partial_ff [3];
   logic             s1_advance;
   logic [7:0]       prev_byte;
   logic [7:0]       recon;
   logic [7:0]       px_red, px_green, px_blue, px_alpha;

   // output register
   logic             out_valid_ff;
   logic [55:0]      out_data_ff;

   logic [7:0]       line_store [STORE_DEPTH];

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         line_pixels_ff     <= LINE_PIX_W'(1);
         bytes_per_pixel_ff <= FMT_RGB;
         rows_per_band_ff   <= BAND_W'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_LINE_PIXELS:   line_pixels_ff     <= csr_pwdata[LINE_PIX_W-1:0];
            REG_BYTES_PER_PIX: bytes_per_pixel_ff <= csr_pwdata[BPP_W-1:0];
            REG_ROWS_PER_BAND: rows_per_band_ff   <= csr_pwdata[BAND_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_LINE_PIXELS:   csr_prdata = CSR_DATA_W'(line_pixels_ff);
         REG_BYTES_PER_PIX: csr_prdata = CSR_DATA_W'(bytes_per_pixel_ff);
         REG_ROWS_PER_BAND: csr_prdata = CSR_DATA_W'(rows_per_band_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------- effective settings ----------------
   always_comb begin
      if (bytes_per_pixel_ff == '0)
         bpp_eff = FMT_ALPHA;
      else if (bytes_per_pixel_ff > BPP_W'(MAX_BYTES_PER_PIXEL))
         bpp_eff = FMT_RGBA;
      else
         bpp_eff = bytes_per_pixel_ff;

      if (line_pixels_ff == '0)
         pix_eff = WIDE_W'(1);
      else if (WIDE_W'(line_pixels_ff) > WIDE_W'(MAX_LINE_PIXELS))
         pix_eff = WIDE_W'(MAX_LINE_PIXELS);
      else
         pix_eff = WIDE_W'(line_pixels_ff);

      unique case (bpp_eff)
         FMT_ALPHA: line_len = pix_eff;
         FMT_PAIR:  line_len = pix_eff << 1;
         FMT_RGB:   line_len = (pix_eff << 1) + pix_eff;
         default:   line_len = pix_eff << 2;
      endcase

      if (rows_per_band_ff == '0)
         band_eff = BAND_W'(1);
      else if (rows_per_band_ff > BAND_W'(MAX_BAND_ROWS))
         band_eff = BAND_W'(MAX_BAND_ROWS);
      else
         band_eff = rows_per_band_ff;
   end

   // ---------------- stage 0: counters and store read ----------------
   assign s1_advance = s1_valid_ff && (!s1_emit_ff || !out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      col0   = req_tuser ? '0 : byte_column_ff;
      band0  = req_tuser ? '0 : band_row_ff;
      row0   = req_tuser ? '0 : image_row_ff;
      ch0    = req_tuser ? '0 : channel_ff;

      complete0 = (BPP_W'(ch0) + BPP_W'(1)) >= bpp_eff;
      end_line0 = (WIDE_W'(col0) + WIDE_W'(1)) >= line_len;

      div3_prod = 32'(col0) * DIV3_MULT;
      unique case (bpp_eff)
         FMT_ALPHA: pcol0 = POS_W'(col0);
         FMT_RGB:   pcol0 = POS_W'(div3_prod >> DIV3_SHIFT);
         FMT_RGBA:  pcol0 = POS_W'(col0 >> 2);
         default:   pcol0 = '0;
      endcase

      if (end_line0) begin
         byte_column_in = '0;
         channel_in     = '0;
         image_row_in   = row0 + ROW_W'(1);
         band_row_in    = ((BAND_W'(band0) + BAND_W'(1)) >= band_eff) ? '0
                                                                     : band0 + ROW_W'(1);
      end else begin
         byte_column_in = col0 + COL_W'(1);
         channel_in     = complete0 ? 2'd0 : ch0 + 2'd1;
         image_row_in   = row0;
         band_row_in    = band0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_column_ff <= '0;
         band_row_ff    <= '0;
         image_row_ff   <= '0;
         channel_ff     <= '0;
      end else if (req_accept) begin
         byte_column_ff <= byte_column_in;
         band_row_ff    <= band_row_in;
         image_row_ff   <= image_row_in;
         channel_ff     <= channel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         s1_valid_ff <= 1'b0;
      else if (req_accept)
         s1_valid_ff <= 1'b1;
      else if (s1_advance)
         s1_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff     <= req_tdata;
         s1_addr_ff     <= col0;
         s1_diff_ff     <= (band0 != '0);
         s1_ch_ff       <= ch0;
         s1_complete_ff <= complete0;
         s1_emit_ff     <= complete0 && (bpp_eff != FMT_PAIR);
         s1_bpp_ff      <= bpp_eff;
         s1_pcol_ff     <= pcol0;
         s1_prow_ff     <= row0;
         fwd_sel_ff     <= s1_advance && (s1_addr_ff == col0);
         fwd_data_ff    <= recon;
      end
   end

   // line store: read on accept, write as stage 1 retires
   always_ff @(posedge clock) begin
      if (req_accept)
         rd_data_ff <= line_store[col0];
      if (s1_advance)
         line_store[s1_addr_ff] <= recon;
   end

   // ---------------- stage 1: reconstruction and pixel assembly ----------------
   always_comb begin
      prev_byte = fwd_sel_ff ? fwd_data_ff : rd_data_ff;
      recon     = s1_diff_ff ? s1_data_ff + prev_byte : s1_data_ff;

      px_red   = '0;
      px_green = '0;
      px_blue  = '0;
      px_alpha = recon;
      unique case (s1_bpp_ff)
         FMT_RGB: begin
            px_red   = partial_ff[0];
            px_green = partial_ff[1];
            px_blue  = recon;
            px_alpha = ALPHA_OPAQUE;
         end
         FMT_RGBA: begin
            px_red   = partial_ff[0];
            px_green = partial_ff[1];
            px_blue  = partial_ff[2];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (s1_advance && !s1_complete_ff && (s1_ch_ff != 2'd3))
         partial_ff[s1_ch_ff] <= recon;
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset)
         out_valid_ff <= 1'b0;
      else if (s1_advance && s1_emit_ff)
         out_valid_ff <= 1'b1;
      else if (rsp_tready)
         out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_emit_ff)
         out_data_ff <= {s1_prow_ff, s1_pcol_ff, px_alpha, px_blue, px_green, px_red};
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // ---------------- assertions ----------------
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("stage 1 empty after accepted request");

   a_rsp_from_s1: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s1_advance && s1_emit_ff))
      else $error("result appeared without a retiring pixel");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !(s1_advance && s1_emit_ff))
      else $error("pending result overwritten");

   a_column_in_store: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (32'(s1_addr_ff) < 32'(STORE_DEPTH)))
      else $error("line store address out of range");

endmodule
